/* rtl/core/pds_pkg.sv */
// Shared types, constants and fixed-point helpers of the disintegrate scatter block.
`default_nettype none
package pds_pkg;

   // request kinds carried on req_tuser
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_RENDER = 1'b1;

   // csr register indexes
   localparam logic [2:0] REG_PROGRESS  = 3'd0;
   localparam logic [2:0] REG_SCATTER   = 3'd1;
   localparam logic [2:0] REG_RED       = 3'd2;
   localparam logic [2:0] REG_GREEN     = 3'd3;
   localparam logic [2:0] REG_BLUE      = 3'd4;
   localparam logic [2:0] REG_DIRECTION = 3'd5;
   localparam logic [2:0] REG_WIDTH     = 3'd6;
   localparam logic [2:0] REG_HEIGHT    = 3'd7;

   // width of frame dimensions, covers sizes up to 4096
   localparam int DIM_W = 13;
   localparam int CMP_W = DIM_W + 1;

   // quarter-wave sine polynomial, Q30
   localparam logic signed [33:0] SA1 = 34'sd1686629713;
   localparam logic signed [33:0] SA3 = -34'sd693598668;
   localparam logic signed [33:0] SA5 = 34'sd85569306;
   localparam logic signed [33:0] SA7 = -34'sd5026995;
   localparam logic signed [33:0] SA9 = 34'sd172272;

   // pixel request as it moves down the pipe
   typedef struct packed {
      logic        cmd;
      logic        bypass;
      logic        inmax;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [31:0] rgba;
   } pds_item_type;

   // request plus blend terms, carried through the angle sine
   typedef struct packed {
      pds_item_type item;
      logic [16:0]  fade;
      logic [14:0]  bright;
      logic [21:0]  dp50;
   } pds_late_type;

   // signed product divided by 2^30, truncated toward zero
   function automatic logic signed [33:0] tdiv30(input logic signed [63:0] prod);
      logic signed [63:0] adj;
      adj = prod[63] ? prod + 64'sd1073741823 : prod;
      return 34'(adj >>> 30);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/pixel_disintegrate_scatter_top.sv */
// Top level of the pixel disintegrate scatter block: config, pipeline, frame store, output skid.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser: command; tdata: x, y, r, g, b, a
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: red, green, blue, alpha
//  csr     | in  | csr_we                 | csr_index, csr_wdata (no read-back)
//
//  One request per clock while the skid register is empty. A render passes the two
//  seven-stage sine steps in turn (hash, then scatter angle as a sine and cosine pair),
//  the multiply stages between them, then the rounding and frame-store read stages.
//  Loads write the store at the same stage where renders read it, so order is kept.
//  Reset is synchronous; it clears valid bits and config, not the frame store.
//  A stalled result moves to a skid register; the pipe freezes only while it is full.
`default_nettype none
module pixel_disintegrate_scatter_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_red, out_green, out_blue, out_alpha
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import pds_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [DIM_W-1:0]  MAX_W_D = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0]  MAX_H_D = DIM_W'(MAX_HEIGHT);
   localparam logic [ADDR_W-1:0] ROW_A   = ADDR_W'(MAX_WIDTH);
   localparam int ITEM_W = $bits(pds_item_type);
   localparam int LATE_W = $bits(pds_late_type);

   localparam logic [31:0] HASH_K1  = 32'd981800619;
   localparam logic [31:0] HASH_K2  = 32'd2613898886;
   localparam logic signed [63:0] HASH_MUL = 64'sd2867760025;
   localparam logic [38:0] RECIP10  = 39'd838861;   // 2^23/10 rounded up, exact for 19-bit

   // round a Q16 value to integer, halves away from zero
   function automatic logic signed [11:0] round_q16(input logic signed [27:0] v);
      logic signed [27:0] m;
      m = v[27] ? -v : v;
      m = (m + 28'sd32768) >>> 16;
      return v[27] ? -12'(m) : 12'(m);
   endfunction

   // ---------------- configuration ----------------
   logic [16:0] progress_ff;
   logic [14:0] scatter_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [15:0] direction_ff;
   logic [8:0]  width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff  <= '0;
         scatter_ff   <= 15'd5120;
         red_ff       <= 8'd128;
         green_ff     <= 8'd128;
         blue_ff      <= 8'd128;
         direction_ff <= '0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PROGRESS:  progress_ff  <= (csr_wdata > 17'd65536) ? 17'd65536 : csr_wdata;
            REG_SCATTER:   scatter_ff   <= (csr_wdata[14:0] > 15'd25600) ? 15'd25600
                                                                           : csr_wdata[14:0];
            REG_RED:       red_ff       <= csr_wdata[7:0];
            REG_GREEN:     green_ff     <= csr_wdata[7:0];
            REG_BLUE:      blue_ff      <= csr_wdata[7:0];
            REG_DIRECTION: direction_ff <= csr_wdata[15:0];
            REG_WIDTH:     width_ff     <= csr_wdata[8:0];
            REG_HEIGHT:    height_ff    <= csr_wdata[8:0];
            default:       ;
         endcase
      end
   end

   // active frame size, clipped to the store
   logic [DIM_W-1:0] act_w, act_h;
   assign act_w = (DIM_W'(width_ff)  > MAX_W_D) ? MAX_W_D : DIM_W'(width_ff);
   assign act_h = (DIM_W'(height_ff) > MAX_H_D) ? MAX_H_D : DIM_W'(height_ff);

   // ---------------- pipeline control ----------------
   logic en;
   logic sk_valid_ff;
   assign en         = !sk_valid_ff;
   assign req_tready = en;

   // ---------------- stage A: capture, hash phase ----------------
   pds_item_type a_item_in, a_item_ff;
   logic [31:0]  a_ph_in, a_ph_ff;
   logic         a_valid_ff;

   always_comb begin
      a_item_in.cmd   = req_tuser;
      a_item_in.x     = req_tdata[7:0];
      a_item_in.y     = req_tdata[15:8];
      a_item_in.rgba  = {req_tdata[47:40], req_tdata[39:32], req_tdata[31:24], req_tdata[23:16]};
      a_item_in.inmax = (DIM_W'(req_tdata[7:0]) < MAX_W_D) && (DIM_W'(req_tdata[15:8]) < MAX_H_D);
      // trivial progress, empty frame or pixel outside it pass the stored pixel
      a_item_in.bypass = (act_w == '0) || (act_h == '0)
                      || (DIM_W'(req_tdata[7:0]) >= act_w) || (DIM_W'(req_tdata[15:8]) >= act_h)
                      || (progress_ff <= 17'd65);
      a_ph_in = {24'd0, req_tdata[7:0]} * HASH_K1 + {24'd0, req_tdata[15:8]} * HASH_K2;
   end

   // ---------------- hash sine ----------------
   logic               s1_valid;
   logic signed [31:0] s1_sine;
   logic [ITEM_W-1:0]  s1_side;

   pds_sine #(.SIDE_W(ITEM_W)) u_hash_sine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_phase  (a_ph_ff),
      .in_side   (a_item_ff),
      .out_valid (s1_valid),
      .out_sine  (s1_sine),
      .out_side  (s1_side)
   );

   // ---------------- stage B: threshold ----------------
   logic [63:0]  b_prod;
   logic [15:0]  b_t_in, b_t_ff;
   pds_item_type b_item_ff;
   logic         b_valid_ff;

   assign b_prod = 64'(64'(s1_sine) * HASH_MUL);
   assign b_t_in = b_prod[45:30];

   // ---------------- stage C: dissolve, angle ----------------
   logic [20:0]        c_p5, c_t4;
   logic signed [20:0] c_draw;
   logic [16:0]        c_d_in, c_d_ff;
   logic signed [16:0] c_tc;
   logic [31:0]        c_ph_in, c_ph_ff;
   logic [18:0]        c_n7_in, c_n7_ff;
   pds_item_type       c_item_in, c_item_ff;
   logic               c_valid_ff;

   always_comb begin
      c_p5   = 21'(progress_ff) * 21'd5;
      c_t4   = {3'd0, b_t_ff, 2'd0};
      c_draw = $signed(c_p5) - $signed(c_t4);
      if (c_draw <= 0) c_d_in = '0;
      else if ((c_draw >>> 1) > 21'sd65536) c_d_in = 17'd65536;
      else c_d_in = 17'(c_draw >>> 1);
      c_tc    = $signed({1'b0, b_t_ff}) - 17'sd32768;
      c_ph_in = {direction_ff, 16'd0} + 32'(32'(c_tc) * 32'sd5215);
      c_n7_in = 19'(b_t_ff) * 19'd7;
      c_item_in = b_item_ff;
      // dissolve too small to show
      if (c_d_in <= 17'd655) c_item_in.bypass = 1'b1;
   end

   // ---------------- stage E: products of dissolve ----------------
   logic [31:0]  e_dist1_in, e_dist1_ff;
   logic [15:0]  e_f_in, e_f_ff;
   logic [33:0]  e_dp_in, e_dp_ff;
   logic [14:0]  e_bright_in, e_bright_ff;
   logic [16:0]  e_fade_in, e_fade_ff;
   logic [31:0]  e_ph_ff;
   pds_item_type e_item_ff;
   logic         e_valid_ff;
   logic [17:0]  e_d3;

   always_comb begin
      e_dist1_in  = 32'(c_d_ff) * 32'(scatter_ff);
      e_f_in      = 16'(39'd19661 + ((39'(c_n7_ff) * RECIP10) >> 23));
      e_dp_in     = 34'(c_d_ff) * 34'(progress_ff);
      e_d3        = 18'(c_d_ff) * 18'd3;
      e_bright_in = 15'((39'(e_d3) * RECIP10) >> 23);
      e_fade_in   = 17'd65536 - 17'(c_d_ff >> 1);
   end

   // ---------------- stage G: distance, upward drift ----------------
   logic [22:0]  g_dist_in, g_dist_ff;
   logic [21:0]  g_dp50_in;
   logic [31:0]  g_ph_ff;
   pds_late_type g_late_ff;
   logic         g_valid_ff;

   assign g_dist_in = 23'((48'(e_dist1_ff) * 48'(e_f_ff)) >> 24);
   assign g_dp50_in = 22'((40'(e_dp_ff) * 40'd50) >> 16);

   // ---------------- angle sine and cosine ----------------
   logic               s2_valid, s3_valid;
   logic signed [31:0] s2_sine, s3_cos;
   logic [LATE_W-1:0]  s2_side;
   logic [22:0]        s3_dist;

   pds_sine #(.SIDE_W(LATE_W)) u_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid_ff),
      .in_phase  (g_ph_ff),
      .in_side   (g_late_ff),
      .out_valid (s2_valid),
      .out_sine  (s2_sine),
      .out_side  (s2_side)
   );

   pds_sine #(.SIDE_W(23)) u_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid_ff),
      .in_phase  (g_ph_ff + 32'h4000_0000),
      .in_side   (g_dist_ff),
      .out_valid (s3_valid),
      .out_sine  (s3_cos),
      .out_side  (s3_dist)
   );

   // ---------------- stage H: offsets ----------------
   logic signed [24:0] h_ox_in, h_ox_ff, h_oy_in, h_oy_ff;
   pds_late_type       h_late_ff;
   logic               h_valid_ff;

   assign h_ox_in = 25'(tdiv30($signed(64'(s3_dist)) * 64'(s3_cos)));
   assign h_oy_in = 25'(tdiv30($signed(64'(s3_dist)) * 64'(s2_sine)));

   // ---------------- stage I: source in Q16 ----------------
   logic signed [27:0] i_vx_in, i_vx_ff, i_vy_in, i_vy_ff;
   pds_late_type       i_late_ff;
   logic               i_valid_ff;

   assign i_vx_in = $signed({4'd0, h_late_ff.item.x, 16'd0}) + 28'(h_ox_ff);
   assign i_vy_in = $signed({4'd0, h_late_ff.item.y, 16'd0}) + 28'(h_oy_ff)
                  - $signed({6'd0, h_late_ff.dp50});

   // ---------------- stage J: rounding, bounds, addresses ----------------
   logic signed [11:0]  j_sx, j_sy;
   logic                j_out_in, j_out_ff;
   logic [ADDR_W-1:0]   j_src_in, j_src_ff, j_here_in, j_here_ff;
   pds_late_type        j_late_ff;
   logic                j_valid_ff;

   always_comb begin
      j_sx = round_q16(i_vx_ff);
      j_sy = round_q16(i_vy_ff);
      j_out_in = j_sx[11] || j_sy[11]
              || ($signed(CMP_W'(j_sx)) >= $signed({1'b0, act_w}))
              || ($signed(CMP_W'(j_sy)) >= $signed({1'b0, act_h}));
      j_src_in  = ADDR_W'($unsigned(j_sy)) * ROW_A + ADDR_W'($unsigned(j_sx));
      j_here_in = ADDR_W'(i_late_ff.item.y) * ROW_A + ADDR_W'(i_late_ff.item.x);
   end

   // ---------------- frame store, stage N ----------------
   logic [31:0]  n_here, n_src;
   logic         n_wr;
   pds_late_type n_late_ff;
   logic         n_out_ff;
   logic         n_valid_ff;

   assign n_wr = en && j_valid_ff && (j_late_ff.item.cmd == CMD_LOAD) && j_late_ff.item.inmax;

   pds_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock     (clock),
      .en        (en),
      .wr_en     (n_wr),
      .wr_addr   (j_here_ff),
      .wr_data   (j_late_ff.item.rgba),
      .rd_addr_a (j_here_ff),
      .rd_addr_b (j_src_ff),
      .rd_data_a (n_here),
      .rd_data_b (n_src)
   );

   // ---------------- stage O: blend and select ----------------
   logic        o_valid_in, o_valid_ff;
   logic [31:0] o_data_in, o_data_ff, sk_data_ff;
   logic [25:0] o_vr, o_vg, o_vb;
   logic [24:0] o_va;

   always_comb begin
      o_vr = (26'(n_src[7:0])   * 26'(n_late_ff.fade) + 26'(red_ff)   * 26'(n_late_ff.bright)) >> 16;
      o_vg = (26'(n_src[15:8])  * 26'(n_late_ff.fade) + 26'(green_ff) * 26'(n_late_ff.bright)) >> 16;
      o_vb = (26'(n_src[23:16]) * 26'(n_late_ff.fade) + 26'(blue_ff)  * 26'(n_late_ff.bright)) >> 16;
      o_va = (25'(n_src[31:24]) * 25'(n_late_ff.fade)) >> 16;
      if (n_late_ff.item.bypass) begin
         o_data_in = n_late_ff.item.inmax ? n_here : 32'd0;
      end else if (n_out_ff) begin
         o_data_in = 32'd0;
      end else begin
         o_data_in = {o_va[7:0],
                      (o_vb > 26'd255) ? 8'd255 : o_vb[7:0],
                      (o_vg > 26'd255) ? 8'd255 : o_vg[7:0],
                      (o_vr > 26'd255) ? 8'd255 : o_vr[7:0]};
      end
      o_valid_in = n_valid_ff && (n_late_ff.item.cmd == CMD_RENDER);
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= s1_valid;
         c_valid_ff <= b_valid_ff;
         e_valid_ff <= c_valid_ff;
         g_valid_ff <= e_valid_ff;
         h_valid_ff <= s2_valid && s3_valid;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         n_valid_ff <= j_valid_ff;
         o_valid_ff <= o_valid_in;
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff   <= a_item_in;
         a_ph_ff     <= a_ph_in;
         b_item_ff   <= pds_item_type'(s1_side);
         b_t_ff      <= b_t_in;
         c_item_ff   <= c_item_in;
         c_d_ff      <= c_d_in;
         c_ph_ff     <= c_ph_in;
         c_n7_ff     <= c_n7_in;
         e_item_ff   <= c_item_ff;
         e_ph_ff     <= c_ph_ff;
         e_dist1_ff  <= e_dist1_in;
         e_f_ff      <= e_f_in;
         e_dp_ff     <= e_dp_in;
         e_bright_ff <= e_bright_in;
         e_fade_ff   <= e_fade_in;
         g_late_ff.item   <= e_item_ff;
         g_late_ff.fade   <= e_fade_ff;
         g_late_ff.bright <= e_bright_ff;
         g_late_ff.dp50   <= g_dp50_in;
         g_dist_ff   <= g_dist_in;
         g_ph_ff     <= e_ph_ff;
         h_late_ff   <= pds_late_type'(s2_side);
         h_ox_ff     <= h_ox_in;
         h_oy_ff     <= h_oy_in;
         i_late_ff   <= h_late_ff;
         i_vx_ff     <= i_vx_in;
         i_vy_ff     <= i_vy_in;
         j_late_ff   <= i_late_ff;
         j_out_ff    <= j_out_in;
         j_src_ff    <= j_src_in;
         j_here_ff   <= j_here_in;
         n_late_ff   <= j_late_ff;
         n_out_ff    <= j_out_ff;
         o_data_ff   <= o_data_in;
      end
   end

   // ---------------- output skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sk_valid_ff <= 1'b0;
      end else if (sk_valid_ff) begin
         if (rsp_tready) sk_valid_ff <= 1'b0;
      end else if (o_valid_ff && !rsp_tready) begin
         sk_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!sk_valid_ff) sk_data_ff <= o_data_ff;
   end

   assign rsp_tvalid = sk_valid_ff || o_valid_ff;
   assign rsp_tdata  = sk_valid_ff ? sk_data_ff : o_data_ff;

endmodule
`default_nettype wire

/* rtl/core/pds_sine.sv */
// Pipelined Q30 sine of a 32-bit turn phase, seven register stages, with side payload.
`default_nettype none
module pds_sine #(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_phase,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic signed [31:0]  out_sine,
   output logic [SIDE_W-1:0]   out_side
);
   import pds_pkg::*;

   localparam int DEPTH = 7;

   logic [DEPTH-1:0]  valid_ff;
   logic [SIDE_W-1:0] side_ff [DEPTH];
   logic [30:0]       z_ff [6];
   logic              neg_ff [6];
   logic [30:0]       q_ff [1:4];
   logic signed [33:0] t_ff [2:5];
   logic signed [31:0] s_ff;

   logic [30:0]        z_in;
   logic [61:0]        zz;
   logic signed [33:0] s_in;

   always_comb begin
      z_in = in_phase[30] ? (31'h4000_0000 - {1'b0, in_phase[29:0]}) : {1'b0, in_phase[29:0]};
      zz   = 62'(z_ff[0]) * 62'(z_ff[0]);
      s_in = tdiv30(64'(t_ff[5]) * $signed(64'(z_ff[5])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < DEPTH; i++) side_ff[i] <= side_ff[i-1];
         z_ff[0]   <= z_in;
         neg_ff[0] <= in_phase[31];
         for (int i = 1; i < 6; i++) begin
            z_ff[i]   <= z_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
         q_ff[1] <= 31'(zz >> 30);
         for (int i = 2; i < 5; i++) q_ff[i] <= q_ff[i-1];
         t_ff[2] <= SA7 + tdiv30(64'(SA9) * $signed(64'(q_ff[1])));
         t_ff[3] <= SA5 + tdiv30(64'(t_ff[2]) * $signed(64'(q_ff[2])));
         t_ff[4] <= SA3 + tdiv30(64'(t_ff[3]) * $signed(64'(q_ff[3])));
         t_ff[5] <= SA1 + tdiv30(64'(t_ff[4]) * $signed(64'(q_ff[4])));
         s_ff    <= neg_ff[5] ? -32'(s_in) : 32'(s_in);
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_sine  = s_ff;
   assign out_side  = side_ff[DEPTH-1];

endmodule
`default_nettype wire

/* rtl/core/pds_store.sv */
// Frame store: one write port and two registered read ports.
`default_nettype none
module pds_store #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              en,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

/* tb/pixel_disintegrate_scatter_top_tb.sv */
// Self-checking testbench of the pixel disintegrate scatter top level.
`timescale 1ns / 1ps
`default_nettype none

// Shadow of the block: frame store, registers and the expected rendered pixels.
class pds_scoreboard;
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint HASH_MUL = 64'sd2867760025;
   localparam longint PS1 = 64'sd1686629713;
   localparam longint PS3 = -64'sd693598668;
   localparam longint PS5 = 64'sd85569306;
   localparam longint PS7 = -64'sd5026995;
   localparam longint PS9 = 64'sd172272;

   bit [31:0] pixels [65536];
   bit        written [65536];
   int        written_list [$];
   int        last_src;
   bit [31:0] pending_pixels [$];
   int        errors;
   longint    progress, scatter, drift, fwidth, fheight;
   longint    tint [3];

   function new();
      progress = 0;
      scatter  = 5120;
      tint[0]  = 128;
      tint[1]  = 128;
      tint[2]  = 128;
      drift    = 0;
      fwidth   = 256;
      fheight  = 256;
      errors   = 0;
      last_src = -1;
   endfunction

   function void write_reg(int idx, bit [16:0] val);
      case (idx)
         pds_pkg::REG_PROGRESS:  progress = (val > 65536) ? 65536 : val;
         pds_pkg::REG_SCATTER:   scatter  = (val[14:0] > 25600) ? 25600 : val[14:0];
         pds_pkg::REG_RED:       tint[0]  = val[7:0];
         pds_pkg::REG_GREEN:     tint[1]  = val[7:0];
         pds_pkg::REG_BLUE:      tint[2]  = val[7:0];
         pds_pkg::REG_DIRECTION: drift    = val[15:0];
         pds_pkg::REG_WIDTH:     fwidth   = val[8:0];
         pds_pkg::REG_HEIGHT:    fheight  = val[8:0];
         default: ;
      endcase
   endfunction

   // quarter-wave folded sine in Q30, truncating divisions
   function longint sine_q30(bit [31:0] ph);
      longint z, z2, acc, s;
      z = ph[29:0];
      if (ph[30]) z = ONE_Q30 - z;
      z2  = z * z / ONE_Q30;
      acc = PS9;
      acc = PS7 + acc * z2 / ONE_Q30;
      acc = PS5 + acc * z2 / ONE_Q30;
      acc = PS3 + acc * z2 / ONE_Q30;
      acc = PS1 + acc * z2 / ONE_Q30;
      s   = acc * z / ONE_Q30;
      return ph[31] ? -s : s;
   endfunction

   function longint round_px(longint v);
      if (v >= 0) return (v + 32768) / 65536;
      return -((-v + 32768) / 65536);
   endfunction

   // expected pixel; last_src holds the gathered address, or -1 when none is read
   function bit [31:0] render(bit [7:0] x, bit [7:0] y);
      longint    w, h, t, d, reach, ox, oy, sx, sy, fade, bright, v;
      bit [31:0] here, ph, src, result;
      logic [63:0] prod;
      last_src = -1;
      w    = (fwidth < 256) ? fwidth : 256;
      h    = (fheight < 256) ? fheight : 256;
      here = pixels[{y, x}];
      if (w == 0 || h == 0 || x >= w || y >= h || progress * 1000 < 65536) return here;
      ph   = x * 32'd981800619 + y * 32'd2613898886;
      prod = sine_q30(ph) * HASH_MUL;
      t    = prod[45:30];
      d    = 5 * progress - 4 * t;
      d    = (d <= 0) ? 0 : d / 2;
      if (d > 65536) d = 65536;
      if (d * 100 < 65536) return here;
      ph    = {drift[15:0], 16'h0000} + 32'((t - 32768) * 5215);
      reach = (d * scatter * (19661 + (7 * t) / 10)) >>> 24;
      ox    = reach * sine_q30(ph + 32'h4000_0000) / ONE_Q30;
      oy    = reach * sine_q30(ph) / ONE_Q30 - ((d * progress * 50) >>> 16);
      sx    = round_px(longint'(x) * 65536 + ox);
      sy    = round_px(longint'(y) * 65536 + oy);
      if (sx < 0 || sx >= w || sy < 0 || sy >= h) return 32'h0;
      last_src = int'(sy * 256 + sx);
      src    = pixels[sy * 256 + sx];
      fade   = 65536 - d / 2;
      bright = (3 * d) / 10;
      for (int c = 0; c < 3; c++) begin
         v = (longint'(src[8*c +: 8]) * fade + tint[c] * bright) >>> 16;
         result[8*c +: 8] = (v > 255) ? 8'd255 : v[7:0];
      end
      v = (longint'(src[31:24]) * fade) >>> 16;
      result[31:24] = v[7:0];
      return result;
   endfunction

   // store address a render of (x, y) gathers from, -1 when it gathers nothing
   function int source_of(bit [7:0] x, bit [7:0] y);
      void'(render(x, y));
      return last_src;
   endfunction

   function void note_request(bit cmd, bit [47:0] data);
      int addr;
      addr = {data[15:8], data[7:0]};
      if (cmd == pds_pkg::CMD_LOAD) begin
         pixels[addr] = data[47:16];
         if (!written[addr]) begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
         end
      end else
         pending_pixels.push_back(render(data[7:0], data[15:8]));
   endfunction

   function void check_result(bit [31:0] got);
      bit [31:0] want;
      string     names [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
      if (pending_pixels.size() == 0) begin
         $error("result 0x%08h with no render pending", got);
         errors++;
         return;
      end
      want = pending_pixels.pop_front();
      for (int f = 0; f < 4; f++)
         if (want[8*f +: 8] !== got[8*f +: 8]) begin
            $error("%s expected %0d actual %0d", names[f], want[8*f +: 8], got[8*f +: 8]);
            errors++;
         end
   endfunction
endclass

module pixel_disintegrate_scatter_top_tb;
   import pds_pkg::*;

   localparam int IDLE_LIMIT  = 4000;  // cycles without any handshake
   localparam int PIPE_FLUSH  = 40;    // loads give no result
   localparam int PHASES      = 10;
   localparam int RANDOM_REQS = 140;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [16:0] csr_wdata;

   pds_scoreboard sb = new();
   int burst_left;
   int idle_cycles;
   int sink_mode, sink_count;
   int pick;

   pixel_disintegrate_scatter_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result sink: always ready, coin flip, or one in four, with the mode re-picked at random
   always @(posedge clock) begin
      sink_count <= sink_count + 1;
      if (sink_count % 600 == 599) sink_mode <= $urandom_range(0, 2);
      case (sink_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (sink_count % 4 == 0);
      endcase
   end

   // every accepted result goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request, held until accepted; most bursts end with a random gap
   task automatic send_request(bit cmd, bit [47:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, data);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic send_pixel(bit cmd, bit [7:0] x, bit [7:0] y, bit [31:0] rgba);
      send_request(cmd, {rgba, y, x});
   endtask

   // render of a written pixel; an unwritten gather source is loaded just before it
   task automatic send_render(bit [7:0] x, bit [7:0] y);
      int src;
      src = sb.source_of(x, y);
      if (src >= 0 && !sb.written[src])
         send_pixel(CMD_LOAD, src[7:0], src[15:8], $urandom);
      send_pixel(CMD_RENDER, x, y, $urandom);
   endtask

   // wait for every pending render, then let any trailing load clear the pipe
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   // csr_we is left high; the caller lowers it after the last write
   task automatic csr_write(logic [2:0] idx, bit [16:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(int phase);
      bit [16:0] v [8];
      v = '{17'd0, 17'd5120, 17'd128, 17'd128, 17'd128, 17'd0, 17'd256, 17'd256};
      case (phase)
         0: ;                                         // tiny progress: pass-through
         1: v = '{17'd65536, 17'd25600, 17'd255, 17'd255, 17'd255, 17'd0, 17'd256, 17'd256};
         2: v[0] = 17'd700;                           // near the tiny-dissolve edge
         3: v = '{17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0, 17'd0, 17'hFFFF, 17'h1FFFF, 17'h1FFFF};
         4: begin v[0] = 17'd40000; v[6] = 17'd0; end // zero width
         5: begin v[0] = 17'd50000; v[6] = 17'd16; v[7] = 17'd300; end
         6: begin v[0] = 17'd65536; v[1] = 17'd0; v[7] = 17'd0; end
         default: begin
            v[0] = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                               : 17'($urandom_range(3000, 65536));
            v[1] = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(0, 25600));
            for (int r = 2; r < 6; r++) v[r] = 17'($urandom);
            v[6] = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(200, 256));
            v[7] = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(200, 256));
         end
      endcase
      for (int r = 0; r < 8; r++) csr_write(3'(r), v[r]);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_LOAD;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_PROGRESS;
      csr_wdata  = '0;
      sink_mode  = 0;
      sink_count = 0;
      idle_cycles = 0;
      burst_left = 1;
      pick       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         configure(phase);
         @(posedge clock);

         // corners with black and white pixels, then a render of each
         send_pixel(CMD_LOAD, 8'd0, 8'd0, 32'h0000_0000);
         send_pixel(CMD_LOAD, 8'd255, 8'd255, 32'hFFFF_FFFF);
         send_pixel(CMD_LOAD, 8'd255, 8'd0, 32'hFFFF_FFFF);
         send_pixel(CMD_LOAD, 8'd0, 8'd255, 32'h0000_0000);
         send_render(8'd0, 8'd0);
         send_render(8'd255, 8'd255);
         send_render(8'd255, 8'd0);
         send_render(8'd0, 8'd255);

         // mostly renders of written pixels, with loads mixed in so reads land on fresh data
         for (int n = 0; n < RANDOM_REQS; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               pick = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
               send_render(pick[7:0], pick[15:8]);
            end else
               send_pixel(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom);
         end
      end

      drain();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire

/* files.f */
rtl/core/pds_pkg.sv
rtl/core/pds_sine.sv
rtl/core/pds_store.sv
rtl/core/pixel_disintegrate_scatter_top.sv
tb/pixel_disintegrate_scatter_top_tb.sv
